/* sv/gn3_pkg.sv */
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
package gn3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int FW        = FRAC_BITS;        // fraction width
    localparam int OW        = FRAC_BITS + 2;    // signed offset width, f or f - ONE
    localparam int GW        = FRAC_BITS + 3;    // gradient dot product width
    localparam int LW        = FRAC_BITS + 4;    // interpolated value width
    localparam int QDEPTH    = 2;

    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } kind_t;

    // Item handed from the front part to the back part.
    typedef struct packed
    {
        logic              is_eval;
        logic [7:0]        tbl_index;
        logic [7:0]        tbl_value;
        logic [7:0]        cx;
        logic [7:0]        cy;
        logic [7:0]        cz;
        logic [FW-1:0]     fx;
        logic [FW-1:0]     fy;
        logic [FW-1:0]     fz;
    } front_item_t;

    // Gradient dot product selected by a 4-bit hash code.
    function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
        input logic signed [OW-1:0] x, input logic signed [OW-1:0] y,
        input logic signed [OW-1:0] z);
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        u = (h < 4'd8) ? GW'(x) : GW'(y);
        if (h < 4'd4)
            v = GW'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = GW'(x);
        else
            v = GW'(z);
        u = h[0] ? -u : u;
        v = h[1] ? -v : v;
        return u + v;
    endfunction

endpackage

/* sv/gn3_front.sv */
// Front part: accept items, split points into cell and fraction, queue for the back part.
module gn3_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      kind,
    input  logic [7:0]                table_index,
    input  logic [7:0]                table_value,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    output logic                      q_valid,
    output gn3_pkg::front_item_t      q_item,
    input  logic                      q_take
);
    gn3_pkg::front_item_t mem_reg [gn3_pkg::QDEPTH];
    logic                 wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]           cnt_reg, cnt_next;
    gn3_pkg::front_item_t in_item;
    logic                 do_push, do_pop;

    always_comb
    begin
        in_item.is_eval   = (kind == gn3_pkg::KIND_EVAL);
        in_item.tbl_index = table_index;
        in_item.tbl_value = table_value;
        in_item.cx        = pos_x[gn3_pkg::FW +: 8];
        in_item.cy        = pos_y[gn3_pkg::FW +: 8];
        in_item.cz        = pos_z[gn3_pkg::FW +: 8];
        in_item.fx        = pos_x[gn3_pkg::FW-1:0];
        in_item.fy        = pos_y[gn3_pkg::FW-1:0];
        in_item.fz        = pos_z[gn3_pkg::FW-1:0];
    end

    assign full    = (cnt_reg == 2'(gn3_pkg::QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign wp_next = do_push ? ~wp_reg : wp_reg;
    assign rp_next = do_pop ? ~rp_reg : rp_reg;
    assign cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

/* sv/gn3_fade.sv */
// Pipelined quintic fade curve, four register stages.
module gn3_fade
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [gn3_pkg::FW-1:0]     f,
    output logic [gn3_pkg::FW:0]       fade
);
    localparam int FW = gn3_pkg::FW;
    localparam logic [FW+4:0] K15 = (FW+5)'(15 * gn3_pkg::ONE);
    localparam logic [FW+4:0] K10 = (FW+5)'(10 * gn3_pkg::ONE);
    localparam logic [2*FW+4:0] HALF = (2*FW+5)'(gn3_pkg::ONE / 2);

    logic [FW-1:0]   f1_reg, f2_reg;
    logic [FW+4:0]   lin_reg;          // 15*ONE - 6f
    logic [FW+4:0]   c_reg, c3_reg;
    logic [FW:0]     sq_reg;
    logic [FW:0]     cube_reg;
    logic [FW:0]     fade_reg;
    logic [2*FW+4:0] p_c, p_sq, p_cube;
    logic [2*FW+6:0] p_r;
    logic [FW+6:0]   r;

    assign p_c    = (2*FW+5)'(f1_reg) * lin_reg;
    assign p_sq   = (2*FW+5)'(f1_reg) * (2*FW+5)'(f1_reg);
    assign p_cube = (2*FW+5)'(sq_reg) * (2*FW+5)'(f2_reg);
    assign p_r    = (2*FW+7)'(cube_reg) * (2*FW+7)'(c3_reg);
    assign r      = (FW+7)'((p_r + (2*FW+7)'(HALF)) >> FW);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg   <= f;
            lin_reg  <= K15 - (FW+5)'(6) * (FW+5)'(f);
            f2_reg   <= f1_reg;
            c_reg    <= K10 - (FW+5)'((p_c + HALF) >> FW);
            sq_reg   <= (FW+1)'((p_sq + HALF) >> FW);
            c3_reg   <= c_reg;
            cube_reg <= (FW+1)'((p_cube + HALF) >> FW);
            fade_reg <= (r > (FW+7)'(gn3_pkg::ONE)) ? (FW+1)'(gn3_pkg::ONE) : (FW+1)'(r);
        end
    end

    assign fade = fade_reg;
endmodule

/* sv/gn3_lerp.sv */
// Registered linear interpolation a + rnd(t*(b-a)).
module gn3_lerp
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [gn3_pkg::FW:0]          t,
    input  logic signed [gn3_pkg::LW-1:0] a,
    input  logic signed [gn3_pkg::LW-1:0] b,
    output logic signed [gn3_pkg::LW-1:0] y
);
    localparam int LW = gn3_pkg::LW;
    localparam int PW = LW + gn3_pkg::FW + 3;
    logic signed [LW:0]    d;
    logic signed [PW-1:0]  p;
    logic signed [LW-1:0]  y_reg;

    assign d = (LW+1)'(b) - (LW+1)'(a);
    assign p = PW'(signed'({1'b0, t})) * PW'(d)
             + PW'(signed'(gn3_pkg::ONE / 2));

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= a + LW'(p >>> gn3_pkg::FW);
    end

    assign y = y_reg;
endmodule

/* sv/gn3_back.sv */
// Back part: hash through the table, gradients, fade, trilinear blend, output queue.
module gn3_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  gn3_pkg::front_item_t                q_item,
    output logic                                q_take,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [17:0]                  noise_value
);
    localparam int FW = gn3_pkg::FW;
    localparam int OW = gn3_pkg::OW;
    localparam int LW = gn3_pkg::LW;
    localparam int NST = 8;             // pipeline depth
    localparam int ODEPTH = 16;         // covers every item in flight plus slack
    localparam int OAW = $clog2(ODEPTH);

    // Table copies: one per read site so each read is a single port per lookup.
    // Each level needs several reads; keep a copy per read site. Each level is written
    // in the cycle after the level above, the same way an evaluate item walks them.
    logic [7:0] t1_reg [2][256];
    logic [7:0] t2_reg [4][256];
    logic [7:0] t3_reg [8][256];
    logic       wr1_reg, wr2_reg;
    logic [7:0] widx1_reg, widx2_reg, wval1_reg, wval2_reg;

    logic [NST-1:0] v_reg;
    logic           adv;
    logic [OAW:0]   ocnt_reg, ocnt_next, inflight;
    logic [OAW-1:0] owp_reg, orp_reg;
    logic signed [17:0] omem_reg [ODEPTH];

    // stage fields
    logic [7:0]  cy1_reg, cz1_reg;
    logic [FW-1:0] fx_s [3];
    logic [FW-1:0] fy_s [3];
    logic [FW-1:0] fz_s [3];
    logic [7:0]  pa_reg, pb_reg;
    logic [7:0]  a_c, b_c;
    logic [7:0]  h2_reg [4];
    logic [7:0]  h3_reg [8];
    logic signed [LW-1:0] g_reg [8];
    logic signed [LW-1:0] x_w [4];
    logic signed [LW-1:0] yy_w [2];
    logic signed [LW-1:0] r_w;
    logic [FW:0] u_w, v_w, w_w;
    logic [FW:0] u1_reg;
    logic [FW:0] v1_reg, v2_reg;
    logic [FW:0] w1_reg, w2_reg, w3_reg;
    logic signed [OW-1:0] ox [2];
    logic signed [OW-1:0] oy [2];
    logic signed [OW-1:0] oz [2];
    logic signed [LW+1:0] rs;
    logic signed [17:0]   sat;
    logic                 wr;
    logic                 go;

    assign inflight = ocnt_reg + (OAW+1)'($countones(v_reg));
    assign q_take   = q_valid && (!q_item.is_eval || inflight < (OAW+1)'(ODEPTH - 1));
    assign go       = q_take && q_item.is_eval;
    assign adv      = 1'b1;
    assign wr       = q_take && !q_item.is_eval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr1_reg <= 1'b0;
            wr2_reg <= 1'b0;
        end
        else
        begin
            wr1_reg <= wr;
            wr2_reg <= wr1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        widx1_reg <= q_item.tbl_index;
        wval1_reg <= q_item.tbl_value;
        widx2_reg <= widx1_reg;
        wval2_reg <= wval1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            for (int i = 0; i < 2; i++) t1_reg[i][q_item.tbl_index] <= q_item.tbl_value;
        end
        if (wr1_reg)
        begin
            for (int i = 0; i < 4; i++) t2_reg[i][widx1_reg] <= wval1_reg;
        end
        if (wr2_reg)
        begin
            for (int i = 0; i < 8; i++) t3_reg[i][widx2_reg] <= wval2_reg;
        end
    end

    // Stage 1: perm(cx), perm(cx+1)
    always_ff @(posedge clk)
    begin
        pa_reg  <= t1_reg[0][q_item.cx];
        pb_reg  <= t1_reg[1][q_item.cx + 8'd1];
        cy1_reg <= q_item.cy;
        cz1_reg <= q_item.cz;
        fx_s[0] <= q_item.fx;
        fy_s[0] <= q_item.fy;
        fz_s[0] <= q_item.fz;
    end

    assign a_c = pa_reg + cy1_reg;
    assign b_c = pb_reg + cy1_reg;

    // Stage 2: aa, ab, ba, bb
    always_ff @(posedge clk)
    begin
        h2_reg[0] <= t2_reg[0][a_c] + cz1_reg;
        h2_reg[1] <= t2_reg[1][a_c + 8'd1] + cz1_reg;
        h2_reg[2] <= t2_reg[2][b_c] + cz1_reg;
        h2_reg[3] <= t2_reg[3][b_c + 8'd1] + cz1_reg;
        fx_s[1] <= fx_s[0];
        fy_s[1] <= fy_s[0];
        fz_s[1] <= fz_s[0];
    end

    // Stage 3: corner hash codes; order aa, ba, ab, bb, aa+1, ba+1, ab+1, bb+1
    always_ff @(posedge clk)
    begin
        h3_reg[0] <= t3_reg[0][h2_reg[0]];
        h3_reg[1] <= t3_reg[1][h2_reg[2]];
        h3_reg[2] <= t3_reg[2][h2_reg[1]];
        h3_reg[3] <= t3_reg[3][h2_reg[3]];
        h3_reg[4] <= t3_reg[4][h2_reg[0] + 8'd1];
        h3_reg[5] <= t3_reg[5][h2_reg[2] + 8'd1];
        h3_reg[6] <= t3_reg[6][h2_reg[1] + 8'd1];
        h3_reg[7] <= t3_reg[7][h2_reg[3] + 8'd1];
        fx_s[2] <= fx_s[1];
        fy_s[2] <= fy_s[1];
        fz_s[2] <= fz_s[1];
    end

    assign ox[0] = OW'(fx_s[2]);
    assign ox[1] = OW'(fx_s[2]) - OW'(gn3_pkg::ONE);
    assign oy[0] = OW'(fy_s[2]);
    assign oy[1] = OW'(fy_s[2]) - OW'(gn3_pkg::ONE);
    assign oz[0] = OW'(fz_s[2]);
    assign oz[1] = OW'(fz_s[2]) - OW'(gn3_pkg::ONE);

    // Stage 4: gradients
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
            g_reg[i] <= LW'(gn3_pkg::grad(h3_reg[i][3:0], ox[i % 2], oy[(i / 2) % 2],
                                          oz[i / 4]));
    end

    // Fade runs from entry: four stages, lands on the same cycle as the gradients.
    gn3_fade u_fade_x (.clk(clk), .en(adv), .f(q_item.fx), .fade(u_w));
    gn3_fade u_fade_y (.clk(clk), .en(adv), .f(q_item.fy), .fade(v_w));
    gn3_fade u_fade_z (.clk(clk), .en(adv), .f(q_item.fz), .fade(w_w));

    // Delay each fade to line up with its lerp level.
    always_ff @(posedge clk)
    begin
        u1_reg <= u_w;
        v1_reg <= v_w;
        v2_reg <= v1_reg;
        w1_reg <= w_w;
        w2_reg <= w1_reg;
        w3_reg <= w2_reg;
    end

    // Stage 5: register the gradients again.
    logic signed [LW-1:0] g5_reg [8];
    always_ff @(posedge clk)
    begin
        g5_reg <= g_reg;
    end

    // Stage 6: lerp in x
    for (genvar i = 0; i < 4; i++)
    begin : g_lx
        gn3_lerp u_lx (.clk(clk), .en(adv), .t(u1_reg), .a(g5_reg[2*i]),
                       .b(g5_reg[2*i+1]), .y(x_w[i]));
    end
    // Stage 7: lerp in y
    for (genvar i = 0; i < 2; i++)
    begin : g_ly
        gn3_lerp u_ly (.clk(clk), .en(adv), .t(v2_reg), .a(x_w[2*i]),
                       .b(x_w[2*i+1]), .y(yy_w[i]));
    end
    // Stage 8: lerp in z
    gn3_lerp u_lz (.clk(clk), .en(adv), .t(w3_reg), .a(yy_w[0]), .b(yy_w[1]), .y(r_w));

    // Scale to 16 fraction bits and saturate.
    always_comb
    begin
        if (FW >= 16)
            rs = (LW+2)'((r_w + LW'(signed'((1 << (FW - 16)) >> 1))) >>> (FW - 16));
        else
            rs = (LW+2)'(r_w) <<< (16 - FW);
        if (rs > (LW+2)'(131071))
            sat = 18'sd131071;
        else if (rs < -(LW+2)'(131072))
            sat = -18'sd131072;
        else
            sat = 18'(rs);
    end

    // Valid pipeline: entry, table lookups, gradients and fades, gradient hold, then x, y and z lerps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NST-2:0], go};
    end

    // Output queue
    assign empty       = (ocnt_reg == '0);
    assign noise_value = omem_reg[orp_reg];
    assign ocnt_next   = ocnt_reg + (OAW+1)'(v_reg[7]) - (OAW+1)'(pop && !empty);

    always_ff @(posedge clk)
    begin
        if (v_reg[7])
            omem_reg[owp_reg] <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            owp_reg  <= '0;
            orp_reg  <= '0;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
            if (v_reg[7])
                owp_reg <= owp_reg + OAW'(1);
            if (pop && !empty)
                orp_reg <= orp_reg + OAW'(1);
        end
    end
endmodule

/* sv/gradient_noise_3d_top.sv */
// Top level of the 3D gradient noise block.
//   channel   direction  handshake         fields
//   input     in         push / full       kind, table_index, table_value, pos_x/y/z
//   result    out        empty / pop       noise_value
// One item per cycle sustained unless an evaluate item waits on results; an evaluate item
// reaches the result ports through the table lookups, gradients, fade and three lerps.
// Load items write the permutation table one hash level per cycle and give no result.
// Reset clears queues and pipeline valids; the table holds garbage until loaded.
// An evaluate item waits at the head of the input queue while 15 results are queued or
// in flight; a load at the head still passes.
module gradient_noise_3d_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] noise_value
);
    logic                 q_valid, q_take;
    gn3_pkg::front_item_t q_item;

    gn3_front u_front (.clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
                       .table_index(table_index), .table_value(table_value),
                       .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
                       .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

    gn3_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
                     .q_take(q_take), .empty(empty), .pop(pop), .noise_value(noise_value));
endmodule

/* sv/gn3_checker.sv */
// Port-level checker for the 3D gradient noise block, bound to the top level.
module gn3_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [17:0] noise_value
);
    a_clear_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty && !full)
        else $error("queues not clear after reset");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("handshake unknown");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(noise_value) && !empty)
        else $error("waiting result changed");
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a transfer");
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(noise_value))
        else $error("result unknown");
endmodule

bind gradient_noise_3d_top gn3_checker u_gn3_checker (.clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .empty(empty), .pop(pop),
    .noise_value(noise_value));
